[rtl/vspal_pkg.sv]
`default_nettype none

package vspal_pkg;

  localparam int ERR_BITS = 12;

  localparam int GAIN_W = 24;
  localparam int ANGLE_W = 32;
  localparam int FRESH_W = 16;
  localparam int THRESH_W = 12;
  localparam int LOCK_W = 16;
  localparam int TIME_W = 32;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam int DIFF_W = ERR_BITS + 1;
  localparam int SUM_W = 26 + ERR_BITS;
  localparam int CMP_W = ((ERR_BITS > THRESH_W) ? ERR_BITS : THRESH_W) + 1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_GAIN_P    = 3'd0,
    CFG_GAIN_D    = 3'd1,
    CFG_FRESHNESS = 3'd2,
    CFG_THRESHOLD = 3'd3,
    CFG_LOCK_SAMP = 3'd4
  } cfg_index_t;

  localparam logic [FRESH_W-1:0] FRESH_RESET = FRESH_W'(100);
  localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(5);
  localparam logic [LOCK_W-1:0] LOCK_RESET = LOCK_W'(5);
  localparam logic [LOCK_W-1:0] LOCK_COUNT_MAX = {LOCK_W{1'b1}};

  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};
  localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};

endpackage

`default_nettype wire

[rtl/visual_servo_pd_aim_lock_unit.sv]
`default_nettype none

// Two-axis PD aiming loop with lock detection. Each transaction is a camera
// sample or a restart, and each gives exactly one result with the yaw and pitch
// commands after that transaction, whether the gimbal was moved, the lock flag
// and whether an angle clipped. Transactions pass an input register and then
// the result register; the angle and lock state is updated combinationally
// between them, so one transaction is taken per clock while out_stall does not
// hold a waiting result. The update runs through the two multipliers per axis
// and the saturating add into the angle registers. Configuration is a plain
// indexed write; the user must do it while the block is idle, which the block
// itself does not enforce; reset needs no clearing pass.
module visual_servo_pd_aim_lock_unit
  import vspal_pkg::*;
(
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           cfg_wen,
  input  wire        [CFG_INDEX_W-1:0]  cfg_index,
  input  wire        [CFG_DATA_W-1:0]   cfg_wdata,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire                           req_type,
  input  wire        [TIME_W-1:0]       now_ms,
  input  wire        [TIME_W-1:0]       rx_stamp_ms,
  input  wire                           target_seen,
  input  wire signed [ERR_BITS-1:0]     error_x,
  input  wire signed [ERR_BITS-1:0]     error_y,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic signed [ANGLE_W-1:0]     yaw_cmd,
  output logic signed [ANGLE_W-1:0]     pitch_cmd,
  output logic                          move_issued,
  output logic                          locked,
  output logic                          angle_saturated
);

  logic signed [GAIN_W-1:0]  gain_p;
  logic signed [GAIN_W-1:0]  gain_d;
  logic        [FRESH_W-1:0] freshness_ms;
  logic        [THRESH_W-1:0] error_threshold_px;
  logic        [LOCK_W-1:0]  lock_samples;

  logic signed [ANGLE_W-1:0]  yaw_angle, yaw_angle_next;
  logic signed [ANGLE_W-1:0]  pitch_angle, pitch_angle_next;
  logic signed [ERR_BITS-1:0] prev_error_x, prev_error_x_next;
  logic signed [ERR_BITS-1:0] prev_error_y, prev_error_y_next;
  logic        [LOCK_W-1:0]   lock_count, lock_count_next;
  logic                       locked_flag, locked_flag_next;

  logic                       s1_valid;
  logic                       s1_req_type;
  logic        [TIME_W-1:0]   s1_now;
  logic        [TIME_W-1:0]   s1_rx;
  logic                       s1_target_seen;
  logic signed [ERR_BITS-1:0] s1_error_x;
  logic signed [ERR_BITS-1:0] s1_error_y;

  logic s1_adv;
  logic move_next;
  logic sat_next;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p <= '0;
      gain_d <= '0;
      freshness_ms <= FRESH_RESET;
      error_threshold_px <= THRESH_RESET;
      lock_samples <= LOCK_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_GAIN_P:    gain_p <= cfg_wdata[GAIN_W-1:0];
        CFG_GAIN_D:    gain_d <= cfg_wdata[GAIN_W-1:0];
        CFG_FRESHNESS: freshness_ms <= cfg_wdata[FRESH_W-1:0];
        CFG_THRESHOLD: error_threshold_px <= cfg_wdata[THRESH_W-1:0];
        CFG_LOCK_SAMP: lock_samples <= cfg_wdata[LOCK_W-1:0];
        default: ;
      endcase
    end
  end

  assign s1_adv = !out_valid || !out_stall;
  assign in_stall = s1_valid && !s1_adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      s1_req_type <= req_type;
      s1_now <= now_ms;
      s1_rx <= rx_stamp_ms;
      s1_target_seen <= target_seen;
      s1_error_x <= error_x;
      s1_error_y <= error_y;
    end
  end

  // pd update
  logic        [TIME_W-1:0]  age;
  logic                      fresh;
  logic signed [DIFF_W-1:0]  diff_x, diff_y;
  logic signed [SUM_W-1:0]   sum_x, sum_y;
  logic                      sat_x, sat_y;
  logic signed [ANGLE_W-1:0] clip_x, clip_y;
  logic        [CMP_W-1:0]   abs_x, abs_y, thresh_ext;
  logic                      on_target;
  logic        [LOCK_W-1:0]  count_inc;

  always_comb begin
    age = s1_now - s1_rx;
    fresh = age <= {{(TIME_W-FRESH_W){1'b0}}, freshness_ms};

    diff_x = DIFF_W'(s1_error_x) - DIFF_W'(prev_error_x);
    diff_y = DIFF_W'(s1_error_y) - DIFF_W'(prev_error_y);
    sum_x = SUM_W'(yaw_angle) + SUM_W'(gain_p) * SUM_W'(s1_error_x)
          + SUM_W'(gain_d) * SUM_W'(diff_x);
    sum_y = SUM_W'(pitch_angle) + SUM_W'(gain_p) * SUM_W'(s1_error_y)
          + SUM_W'(gain_d) * SUM_W'(diff_y);

    sat_x = (sum_x[SUM_W-1:ANGLE_W-1] != '0) && (sum_x[SUM_W-1:ANGLE_W-1] != '1);
    sat_y = (sum_y[SUM_W-1:ANGLE_W-1] != '0) && (sum_y[SUM_W-1:ANGLE_W-1] != '1);
    clip_x = sat_x ? (sum_x[SUM_W-1] ? ANGLE_MIN : ANGLE_MAX) : sum_x[ANGLE_W-1:0];
    clip_y = sat_y ? (sum_y[SUM_W-1] ? ANGLE_MIN : ANGLE_MAX) : sum_y[ANGLE_W-1:0];

    abs_x = s1_error_x[ERR_BITS-1] ? CMP_W'(-DIFF_W'(s1_error_x)) : CMP_W'(s1_error_x);
    abs_y = s1_error_y[ERR_BITS-1] ? CMP_W'(-DIFF_W'(s1_error_y)) : CMP_W'(s1_error_y);
    thresh_ext = CMP_W'(error_threshold_px);
    on_target = (abs_x < thresh_ext) && (abs_y < thresh_ext);
    count_inc = (lock_count == LOCK_COUNT_MAX) ? lock_count : lock_count + LOCK_W'(1);

    yaw_angle_next = yaw_angle;
    pitch_angle_next = pitch_angle;
    prev_error_x_next = prev_error_x;
    prev_error_y_next = prev_error_y;
    lock_count_next = lock_count;
    locked_flag_next = locked_flag;
    move_next = 1'b0;
    sat_next = 1'b0;

    if (s1_req_type) begin
      yaw_angle_next = '0;
      pitch_angle_next = '0;
      prev_error_x_next = '0;
      prev_error_y_next = '0;
      lock_count_next = '0;
      locked_flag_next = 1'b0;
      move_next = 1'b1;
    end else if (fresh) begin
      if (!s1_target_seen) begin
        lock_count_next = '0;
        locked_flag_next = 1'b0;
      end else begin
        yaw_angle_next = clip_x;
        pitch_angle_next = clip_y;
        prev_error_x_next = s1_error_x;
        prev_error_y_next = s1_error_y;
        move_next = 1'b1;
        sat_next = sat_x || sat_y;
        if (on_target) begin
          lock_count_next = count_inc;
          if (count_inc >= lock_samples) begin
            locked_flag_next = 1'b1;
          end
        end else begin
          lock_count_next = '0;
          locked_flag_next = 1'b0;
        end
      end
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_angle <= '0;
      pitch_angle <= '0;
      prev_error_x <= '0;
      prev_error_y <= '0;
      lock_count <= '0;
      locked_flag <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_adv) begin
        out_valid <= s1_valid;
      end
      if (s1_valid && s1_adv) begin
        yaw_angle <= yaw_angle_next;
        pitch_angle <= pitch_angle_next;
        prev_error_x <= prev_error_x_next;
        prev_error_y <= prev_error_y_next;
        lock_count <= lock_count_next;
        locked_flag <= locked_flag_next;
      end
    end
    if (s1_valid && s1_adv) begin
      yaw_cmd <= yaw_angle_next;
      pitch_cmd <= pitch_angle_next;
      move_issued <= move_next;
      locked <= locked_flag_next;
      angle_saturated <= sat_next;
    end
  end

  a_out_matches_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (yaw_cmd == yaw_angle) && (pitch_cmd == pitch_angle)
                  && (locked == locked_flag))
    else $error("result register out of step with angle state");

  a_sat_needs_move: assert property (@(posedge clk) disable iff (rst)
    out_valid && !move_issued |-> !angle_saturated)
    else $error("saturation flagged without a move");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_adv && s1_req_type |=>
      out_valid && (yaw_cmd == '0) && (pitch_cmd == '0) && move_issued && !locked
      && (lock_count == '0))
    else $error("restart did not clear state");

  a_empty_no_stall: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !in_stall)
    else $error("input stalled with empty input register");

  a_lock_needs_count: assert property (@(posedge clk) disable iff (rst)
    locked_flag |-> (lock_count != '0))
    else $error("lock set with zero lock count");

endmodule

`default_nettype wire

[verif/vspal_checker.sv]
module vspal_checker
  import vspal_pkg::*;
(
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        cfg_wen,
  input  wire        [CFG_INDEX_W-1:0] cfg_index,
  input  wire        [CFG_DATA_W-1:0]  cfg_wdata,
  input  wire                        in_valid,
  input  wire                        in_stall,
  input  wire                        req_type,
  input  wire        [TIME_W-1:0]    now_ms,
  input  wire        [TIME_W-1:0]    rx_stamp_ms,
  input  wire                        target_seen,
  input  wire signed [ERR_BITS-1:0]  error_x,
  input  wire signed [ERR_BITS-1:0]  error_y,
  input  wire                        out_valid,
  input  wire                        out_stall,
  input  wire signed [ANGLE_W-1:0]   yaw_cmd,
  input  wire signed [ANGLE_W-1:0]   pitch_cmd,
  input  wire                        move_issued,
  input  wire                        locked,
  input  wire                        angle_saturated,
  output int                         errors,
  output int                         outstanding
);

  typedef struct packed {
    logic signed [ANGLE_W-1:0] yaw;
    logic signed [ANGLE_W-1:0] pitch;
    logic                      move;
    logic                      lock;
    logic                      clipped;
  } aim_cmd_t;

  aim_cmd_t expected_cmds[$];

  logic signed [GAIN_W-1:0]   kp;
  logic signed [GAIN_W-1:0]   kd;
  logic        [FRESH_W-1:0]  max_age;
  logic        [THRESH_W-1:0] on_target_px;
  logic        [LOCK_W-1:0]   lock_need;

  logic signed [ANGLE_W-1:0]  yaw_deg;
  logic signed [ANGLE_W-1:0]  pitch_acc;
  logic signed [ERR_BITS-1:0] last_ex;
  logic signed [ERR_BITS-1:0] last_ey;
  logic        [LOCK_W-1:0]   hold_count;
  logic                       hold_lock;

  // incremental pd step on one axis, clipped to the angle range
  function automatic logic signed [ANGLE_W-1:0] step_angle(
    input  logic signed [ANGLE_W-1:0]  angle,
    input  logic signed [ERR_BITS-1:0] err,
    input  logic signed [ERR_BITS-1:0] prev,
    output logic                       clipped
  );
    longint sum;
    sum = longint'(angle) + longint'(kp) * longint'(err)
        + longint'(kd) * (longint'(err) - longint'(prev));
    clipped = 1'b0;
    if (sum > longint'(ANGLE_MAX)) begin
      clipped = 1'b1;
      return ANGLE_MAX;
    end
    if (sum < longint'(ANGLE_MIN)) begin
      clipped = 1'b1;
      return ANGLE_MIN;
    end
    return sum[ANGLE_W-1:0];
  endfunction

  always @(posedge clk) begin : watch
    aim_cmd_t          want;
    aim_cmd_t          got;
    logic [TIME_W-1:0] age;
    logic              clip_y;
    logic              clip_p;
    logic              moved;
    int                ax;
    int                ay;
    if (rst) begin
      kp = '0;
      kd = '0;
      max_age = FRESH_RESET;
      on_target_px = THRESH_RESET;
      lock_need = LOCK_RESET;
      yaw_deg = '0;
      pitch_acc = '0;
      last_ex = '0;
      last_ey = '0;
      hold_count = '0;
      hold_lock = 1'b0;
      errors = 0;
      expected_cmds.delete();
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          CFG_GAIN_P:    kp = cfg_wdata[GAIN_W-1:0];
          CFG_GAIN_D:    kd = cfg_wdata[GAIN_W-1:0];
          CFG_FRESHNESS: max_age = cfg_wdata[FRESH_W-1:0];
          CFG_THRESHOLD: on_target_px = cfg_wdata[THRESH_W-1:0];
          CFG_LOCK_SAMP: lock_need = cfg_wdata[LOCK_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        clip_y = 1'b0;
        clip_p = 1'b0;
        moved = 1'b0;
        if (req_type) begin
          yaw_deg = '0;
          pitch_acc = '0;
          last_ex = '0;
          last_ey = '0;
          hold_count = '0;
          hold_lock = 1'b0;
          moved = 1'b1;
        end else begin
          age = now_ms - rx_stamp_ms;
          if (age <= max_age) begin
            if (!target_seen) begin
              hold_count = '0;
              hold_lock = 1'b0;
            end else begin
              yaw_deg = step_angle(yaw_deg, error_x, last_ex, clip_y);
              pitch_acc = step_angle(pitch_acc, error_y, last_ey, clip_p);
              last_ex = error_x;
              last_ey = error_y;
              moved = 1'b1;
              ax = (error_x < 0) ? -int'(error_x) : int'(error_x);
              ay = (error_y < 0) ? -int'(error_y) : int'(error_y);
              if (ax < int'(on_target_px) && ay < int'(on_target_px)) begin
                if (hold_count != LOCK_COUNT_MAX) hold_count++;
                if (hold_count >= lock_need) hold_lock = 1'b1;
              end else begin
                hold_count = '0;
                hold_lock = 1'b0;
              end
            end
          end
        end
        want.yaw = yaw_deg;
        want.pitch = pitch_acc;
        want.move = moved;
        want.lock = hold_lock;
        want.clipped = clip_y | clip_p;
        expected_cmds.push_back(want);
      end

      if (out_valid && !out_stall) begin
        got.yaw = yaw_cmd;
        got.pitch = pitch_cmd;
        got.move = move_issued;
        got.lock = locked;
        got.clipped = angle_saturated;
        if (expected_cmds.size() == 0) begin
          if (errors < 10)
            $display("unexpected result transaction: yaw %0d pitch %0d", yaw_cmd, pitch_cmd);
          errors++;
        end else begin
          want = expected_cmds.pop_front();
          if (got !== want) begin
            if (errors < 10) begin
              $display("mismatch: expected yaw %0d pitch %0d move %0b lock %0b sat %0b",
                       want.yaw, want.pitch, want.move, want.lock, want.clipped);
              $display("          actual   yaw %0d pitch %0d move %0b lock %0b sat %0b",
                       got.yaw, got.pitch, got.move, got.lock, got.clipped);
            end
            errors++;
          end
        end
      end
    end
    outstanding = expected_cmds.size();
  end

endmodule

[verif/tb_top.sv]
module tb_top;
  import vspal_pkg::*;

  localparam int LIMIT = 20000;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_wen;
  logic        [CFG_INDEX_W-1:0] cfg_index;
  logic        [CFG_DATA_W-1:0]  cfg_wdata;
  logic                       in_valid;
  logic                       in_stall;
  logic                       req_type;
  logic        [TIME_W-1:0]   now_ms;
  logic        [TIME_W-1:0]   rx_stamp_ms;
  logic                       target_seen;
  logic signed [ERR_BITS-1:0] error_x;
  logic signed [ERR_BITS-1:0] error_y;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [ANGLE_W-1:0]  yaw_cmd;
  logic signed [ANGLE_W-1:0]  pitch_cmd;
  logic                       move_issued;
  logic                       locked;
  logic                       angle_saturated;

  int                         errors;
  int                         outstanding;
  logic                       in_taken = 1'b0;
  logic                       calm = 1'b0;
  logic        [FRESH_W-1:0]  cur_fresh;
  logic        [THRESH_W-1:0] cur_thr;

  visual_servo_pd_aim_lock_unit i_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_wen         (cfg_wen),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .req_type        (req_type),
    .now_ms          (now_ms),
    .rx_stamp_ms     (rx_stamp_ms),
    .target_seen     (target_seen),
    .error_x         (error_x),
    .error_y         (error_y),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .yaw_cmd         (yaw_cmd),
    .pitch_cmd       (pitch_cmd),
    .move_issued     (move_issued),
    .locked          (locked),
    .angle_saturated (angle_saturated)
  );

  vspal_checker i_aim_check (
    .clk             (clk),
    .rst             (rst),
    .cfg_wen         (cfg_wen),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .req_type        (req_type),
    .now_ms          (now_ms),
    .rx_stamp_ms     (rx_stamp_ms),
    .target_seen     (target_seen),
    .error_x         (error_x),
    .error_y         (error_y),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .yaw_cmd         (yaw_cmd),
    .pitch_cmd       (pitch_cmd),
    .move_issued     (move_issued),
    .locked          (locked),
    .angle_saturated (angle_saturated),
    .errors          (errors),
    .outstanding     (outstanding)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) in_taken <= in_valid && !in_stall;

  always @(negedge clk) out_stall <= !calm && ($urandom_range(99) < 16);

  task automatic wait_drained();
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic send_item(
    input logic                       req,
    input logic        [TIME_W-1:0]   now_v,
    input logic        [TIME_W-1:0]   rx_v,
    input logic                       tv,
    input logic signed [ERR_BITS-1:0] ex,
    input logic signed [ERR_BITS-1:0] ey
  );
    while (!calm && $urandom_range(99) < 16) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    req_type = req;
    now_ms = now_v;
    rx_stamp_ms = rx_v;
    target_seen = tv;
    error_x = ex;
    error_y = ey;
    do @(negedge clk); while (!in_taken);
    in_valid = 1'b0;
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wen = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_wen = 1'b0;
  endtask

  task automatic set_config(
    input logic [GAIN_W-1:0]   p_gain,
    input logic [GAIN_W-1:0]   d_gain,
    input logic [FRESH_W-1:0]  fresh,
    input logic [THRESH_W-1:0] thr,
    input logic [LOCK_W-1:0]   need
  );
    wait_drained();
    write_reg(CFG_GAIN_P, p_gain);
    write_reg(CFG_GAIN_D, d_gain);
    write_reg(CFG_FRESHNESS, CFG_DATA_W'(fresh));
    write_reg(CFG_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(CFG_LOCK_SAMP, CFG_DATA_W'(need));
    cur_fresh = fresh;
    cur_thr = thr;
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    int g;
    case ($urandom_range(9))
      0: g = 8388607;
      1: g = -8388608;
      2, 3, 4: g = $urandom;
      default: g = int'($urandom_range(262143)) - 131072;
    endcase
    return g[GAIN_W-1:0];
  endfunction

  // mode: below 6 on target, 6 at the threshold, 7..8 anywhere, 9 extremes
  function automatic logic signed [ERR_BITS-1:0] pick_error(input int mode);
    int t;
    int v;
    if (mode < 6) begin
      t = (cur_thr == 0) ? 0 : int'(cur_thr) - 1;
      v = int'($urandom_range(2 * t)) - t;
    end else if (mode == 6) begin
      v = $urandom_range(1) ? int'(cur_thr) : -int'(cur_thr);
    end else if (mode < 9) begin
      v = $urandom;
    end else begin
      case ($urandom_range(3))
        0: v = 2047;
        1: v = -2048;
        2: v = 0;
        default: v = -1;
      endcase
    end
    return v[ERR_BITS-1:0];
  endfunction

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int                i;
    int                n;
    int                burst;
    int                mode;
    logic [TIME_W-1:0] now_v;
    logic [TIME_W-1:0] age;
    logic [FRESH_W-1:0]  f_pick;
    logic [THRESH_W-1:0] t_pick;
    logic [LOCK_W-1:0]   l_pick;
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_index = CFG_GAIN_P;
    cfg_wdata = '0;
    in_valid = 1'b0;
    req_type = 1'b0;
    now_ms = '0;
    rx_stamp_ms = '0;
    target_seen = 1'b0;
    error_x = '0;
    error_y = '0;
    cur_fresh = FRESH_RESET;
    cur_thr = THRESH_RESET;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // reset settings: lock after five on-target samples, age limit boundary
    send_item(1'b1, 0, 0, 1'b0, 0, 0);
    for (i = 0; i < 6; i++)
      send_item(1'b0, 1000, 1000 - i * 20, 1'b1, ERR_BITS'(4 - i), ERR_BITS'(i - 4));
    send_item(1'b0, 1000, 899, 1'b1, 0, 0);
    send_item(1'b0, 1000, 950, 1'b0, 0, 0);

    // extreme gains, zero age limit, widest threshold, lock on first on-target sample
    set_config(24'h7FFFFF, 24'h800000, 16'd0, 12'd2048, 16'd0);
    send_item(1'b0, 7, 7, 1'b1, 2047, -2048);
    send_item(1'b0, 7, 7, 1'b1, -2048, 2047);
    send_item(1'b0, 7, 7, 1'b1, 0, 0);
    send_item(1'b0, 0, 32'hFFFFFFFF, 1'b1, 1, 1);
    send_item(1'b1, $urandom, $urandom, 1'b1, -2048, 2047);

    // widest age limit across the time wrap, lock persistence
    set_config(24'h010000, 24'h008000, 16'hFFFF, 12'd5, 16'd3);
    send_item(1'b0, 32'h0000FFF0, 32'hFFFFFFF0, 1'b1, 0, 0);
    send_item(1'b0, 32'h0000FFEF, 32'hFFFFFFF0, 1'b1, 3, -3);
    send_item(1'b0, 10, 10, 1'b1, -4, 4);
    send_item(1'b0, 10, 10, 1'b1, 2, 1);
    send_item(1'b0, 100000, 0, 1'b1, 100, 100);
    send_item(1'b0, 10, 10, 1'b1, 0, 0);
    send_item(1'b0, 10, 10, 1'b1, 5, 0);

    // lock builds over a long on-target run
    set_config(24'h000100, 24'hFFFF00, 16'hFFFF, 12'd2048, 16'd40);
    calm = 1'b1;
    for (i = 0; i < 48; i++) begin
      now_v = $urandom;
      send_item(1'b0, now_v, now_v - $urandom_range(65535), 1'b1,
                pick_error(0), pick_error(0));
    end
    send_item(1'b0, 5, 5, 1'b1, -2048, 0);
    calm = 1'b0;

    for (int p = 0; p < 5; p++) begin
      case ($urandom_range(4))
        0: f_pick = 16'd0;
        1: f_pick = 16'hFFFF;
        2: f_pick = FRESH_W'($urandom_range(65535));
        default: f_pick = FRESH_W'($urandom_range(400, 10));
      endcase
      case ($urandom_range(4))
        0: t_pick = 12'd0;
        1: t_pick = 12'd2048;
        2: t_pick = THRESH_W'($urandom_range(2048));
        default: t_pick = THRESH_W'($urandom_range(16, 1));
      endcase
      case ($urandom_range(9))
        0: l_pick = 16'hFFFF;
        1: l_pick = LOCK_W'($urandom_range(65535, 1));
        default: l_pick = LOCK_W'($urandom_range(6, 1));
      endcase
      set_config(pick_gain(), pick_gain(), f_pick, t_pick, l_pick);
      calm = (p == 1);
      n = 0;
      while (n < 126) begin
        burst = $urandom_range(10, 1);
        mode = $urandom_range(9);
        for (i = 0; i < burst; i++) begin
          if (p == 2 && n == 70) wait_drained();
          now_v = $urandom;
          case ($urandom_range(19))
            16, 17, 18: age = cur_fresh + 1 + $urandom_range(1000);
            19: age = $urandom;
            default: age = $urandom_range(cur_fresh);
          endcase
          send_item($urandom_range(49) == 0, now_v, now_v - age,
                    $urandom_range(19) != 0, pick_error(mode), pick_error(mode));
          n++;
        end
      end
    end
    calm = 1'b0;

    wait_drained();
    repeat (8) @(negedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/vspal_pkg.sv
rtl/visual_servo_pd_aim_lock_unit.sv
verif/vspal_checker.sv
verif/tb_top.sv
